[rtl/ejck_pkg.sv]
`default_nettype none
package ejck_pkg;

  localparam int VW = 40;
  localparam int RAW = 5;
  localparam int RF_DEPTH = 23;

  typedef logic signed [VW-1:0] val_t;
  typedef logic [RAW-1:0] ra_t;

  localparam val_t ONE_Q30 = 40'sd1073741824;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] QUARTER_PI_Q30 = 34'sd843314856;

  localparam ra_t RA_M0  = 5'd0;
  localparam ra_t RA_T0  = 5'd9;
  localparam ra_t RA_T1  = 5'd10;
  localparam ra_t RA_R   = 5'd11;
  localparam ra_t RA_X2  = 5'd12;
  localparam ra_t RA_T   = 5'd13;
  localparam ra_t RA_TMP = 5'd14;
  localparam ra_t RA_S   = 5'd15;
  localparam ra_t RA_C   = 5'd16;
  localparam ra_t RA_SX  = 5'd17;
  localparam ra_t RA_CX  = 5'd18;
  localparam ra_t RA_SY  = 5'd19;
  localparam ra_t RA_CY  = 5'd20;
  localparam ra_t RA_SZ  = 5'd21;
  localparam ra_t RA_CZ  = 5'd22;

  localparam logic [4:0] TRIG_LAST = 5'd17;

  typedef enum logic [2:0] {OP_QMUL, OP_DIV, OP_MOV, OP_QSIN, OP_QCOS} op_e;
  typedef enum logic [2:0] {D72, D42, D20, D6, D56, D30, D12, D2} div_e;
  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_e;
  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_RED, ST_OPRD, ST_OPST, ST_OPWT, ST_WAIT, ST_OUT
  } state_e;

  typedef struct packed {
    op_e  op;
    ra_t  a;
    ra_t  b;
    ra_t  c;
    ra_t  dst;
    logic acc;
    logic neg;
    div_e dix;
  } uop_t;

  typedef struct packed {
    op_e        op;
    div_e       dix;
    logic       acc;
    logic       neg;
    logic [1:0] k;
  } alu_req_t;

  function automatic logic [6:0] div_d(div_e dx);
    logic [6:0] d;
    unique case (dx)
      D72: d = 7'd72;
      D42: d = 7'd42;
      D20: d = 7'd20;
      D6:  d = 7'd6;
      D56: d = 7'd56;
      D30: d = 7'd30;
      D12: d = 7'd12;
      D2:  d = 7'd2;
      default: d = 7'd2;
    endcase
    return d;
  endfunction

  // Reciprocals scaled by 2^31, rounded down.
  function automatic logic [31:0] div_m(div_e dx);
    logic [31:0] m;
    unique case (dx)
      D72: m = 32'd29826161;
      D42: m = 32'd51130563;
      D20: m = 32'd107374182;
      D6:  m = 32'd357913941;
      D56: m = 32'd38347922;
      D30: m = 32'd71582788;
      D12: m = 32'd178956970;
      D2:  m = 32'd1073741824;
      default: m = 32'd1073741824;
    endcase
    return m;
  endfunction

  function automatic uop_t mk(op_e op, ra_t a, ra_t b, ra_t c, ra_t dst,
                              logic acc, logic neg, div_e dix);
    uop_t u;
    u.op = op;
    u.a = a;
    u.b = b;
    u.c = c;
    u.dst = dst;
    u.acc = acc;
    u.neg = neg;
    u.dix = dix;
    return u;
  endfunction

  function automatic uop_t trig_uop(logic [4:0] pc, logic [1:0] ang);
    ra_t qd;
    uop_t u;
    qd = RA_SX + {2'b00, ang, 1'b0};
    unique case (pc)
      5'd0:  u = mk(OP_QMUL, RA_R, RA_R, RA_T0, RA_X2, 1'b0, 1'b0, D2);
      5'd1:  u = mk(OP_DIV, RA_X2, RA_X2, RA_T0, RA_T, 1'b0, 1'b0, D72);
      5'd2:  u = mk(OP_QMUL, RA_X2, RA_T, RA_T0, RA_TMP, 1'b0, 1'b0, D2);
      5'd3:  u = mk(OP_DIV, RA_TMP, RA_TMP, RA_T0, RA_T, 1'b0, 1'b0, D42);
      5'd4:  u = mk(OP_QMUL, RA_X2, RA_T, RA_T0, RA_TMP, 1'b0, 1'b0, D2);
      5'd5:  u = mk(OP_DIV, RA_TMP, RA_TMP, RA_T0, RA_T, 1'b0, 1'b0, D20);
      5'd6:  u = mk(OP_QMUL, RA_X2, RA_T, RA_T0, RA_TMP, 1'b0, 1'b0, D2);
      5'd7:  u = mk(OP_DIV, RA_TMP, RA_TMP, RA_T0, RA_T, 1'b0, 1'b0, D6);
      5'd8:  u = mk(OP_QMUL, RA_R, RA_T, RA_T0, RA_S, 1'b0, 1'b0, D2);
      5'd9:  u = mk(OP_DIV, RA_X2, RA_X2, RA_T0, RA_T, 1'b0, 1'b0, D56);
      5'd10: u = mk(OP_QMUL, RA_X2, RA_T, RA_T0, RA_TMP, 1'b0, 1'b0, D2);
      5'd11: u = mk(OP_DIV, RA_TMP, RA_TMP, RA_T0, RA_T, 1'b0, 1'b0, D30);
      5'd12: u = mk(OP_QMUL, RA_X2, RA_T, RA_T0, RA_TMP, 1'b0, 1'b0, D2);
      5'd13: u = mk(OP_DIV, RA_TMP, RA_TMP, RA_T0, RA_T, 1'b0, 1'b0, D12);
      5'd14: u = mk(OP_QMUL, RA_X2, RA_T, RA_T0, RA_TMP, 1'b0, 1'b0, D2);
      5'd15: u = mk(OP_DIV, RA_TMP, RA_TMP, RA_T0, RA_C, 1'b0, 1'b0, D2);
      5'd16: u = mk(OP_QSIN, RA_S, RA_C, RA_T0, qd, 1'b0, 1'b0, D2);
      5'd17: u = mk(OP_QCOS, RA_S, RA_C, RA_T0, qd + 5'd1, 1'b0, 1'b0, D2);
      default: u = mk(OP_MOV, RA_T0, RA_T0, RA_T0, RA_T0, 1'b0, 1'b0, D2);
    endcase
    return u;
  endfunction

  // One row of a right-multiplication by an axis rotation: columns u and v change.
  function automatic uop_t rot_uop(logic [2:0] step, logic [1:0] row, axis_e ax);
    ra_t base;
    ra_t au;
    ra_t av;
    ra_t rs;
    ra_t rc;
    uop_t u;
    base = {3'b000, row} + {2'b00, row, 1'b0};
    unique case (ax)
      AX_X: begin
        au = base + 5'd1;
        av = base + 5'd2;
        rs = RA_SX;
        rc = RA_CX;
      end
      AX_Y: begin
        au = base + 5'd2;
        av = base;
        rs = RA_SY;
        rc = RA_CY;
      end
      default: begin
        au = base;
        av = base + 5'd1;
        rs = RA_SZ;
        rc = RA_CZ;
      end
    endcase
    unique case (step)
      3'd0: u = mk(OP_QMUL, au, rc, RA_T0, RA_T0, 1'b0, 1'b0, D2);
      3'd1: u = mk(OP_QMUL, av, rs, RA_T0, RA_T0, 1'b1, 1'b0, D2);
      3'd2: u = mk(OP_QMUL, av, rc, RA_T1, RA_T1, 1'b0, 1'b0, D2);
      3'd3: u = mk(OP_QMUL, au, rs, RA_T1, av, 1'b1, 1'b1, D2);
      default: u = mk(OP_MOV, RA_T0, RA_T0, RA_T0, au, 1'b0, 1'b0, D2);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

[rtl/ejck_alu.sv]
`default_nettype none
module ejck_alu (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire ejck_pkg::alu_req_t req_i,
  input  wire ejck_pkg::val_t     a_i,
  input  wire ejck_pkg::val_t     b_i,
  input  wire ejck_pkg::val_t     c_i,
  output logic                    done_o,
  output ejck_pkg::val_t          res_o
);

  ejck_pkg::alu_req_t req_q;
  ejck_pkg::val_t     a_q;
  ejck_pkg::val_t     b_q;
  logic               sign_q;
  logic [39:0]        ma_q;
  logic [31:0]        mb_q;
  logic [51:0]        plo_q;
  logic [71:0]        prod_q;
  logic [39:0]        mag_q;
  logic [3:0]         v_q;

  logic [39:0] a_abs;
  logic [39:0] b_abs;
  logic [39:0] ma_d;
  logic [31:0] mb_d;
  logic        sign_d;
  logic [6:0]  dd;
  logic [31:0] q0;
  logic [38:0] qd;
  logic [39:0] rem;
  logic [39:0] mag_d;
  logic [71:0] rnd;
  ejck_pkg::val_t smag;

  always_comb begin
    a_abs = a_i[39] ? 40'(-a_i) : 40'(a_i);
    b_abs = b_i[39] ? 40'(-b_i) : 40'(b_i);
    if (req_i.op == ejck_pkg::OP_DIV) begin
      ma_d = a_abs + 40'(ejck_pkg::div_d(req_i.dix) >> 1);
      mb_d = ejck_pkg::div_m(req_i.dix);
      sign_d = a_i[39];
    end else begin
      ma_d = a_abs;
      mb_d = b_abs[31:0];
      sign_d = a_i[39] ^ b_i[39] ^ req_i.neg;
    end
  end

  always_comb begin
    dd = ejck_pkg::div_d(req_q.dix);
    q0 = prod_q[62:31];
    qd = 39'(q0) * 39'(dd);
    rem = ma_q - 40'(qd);
    rnd = prod_q + 72'd536870912;
    if (req_q.op == ejck_pkg::OP_DIV) begin
      mag_d = 40'(q0) + 40'(rem >= 40'(dd));
    end else begin
      mag_d = rnd[69:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
      a_q <= a_i;
      b_q <= b_i;
      sign_q <= sign_d;
      ma_q <= ma_d;
      mb_q <= mb_d;
    end
    plo_q <= 52'(ma_q[19:0]) * 52'(mb_q);
    prod_q <= 72'(plo_q) + (72'(52'(ma_q[39:20]) * 52'(mb_q)) << 20);
    mag_q <= mag_d;
  end

  always_comb begin
    smag = sign_q ? -$signed(mag_q) : $signed(mag_q);
    unique case (req_q.op)
      ejck_pkg::OP_QMUL: res_o = req_q.acc ? c_i + smag : smag;
      ejck_pkg::OP_DIV:  res_o = ejck_pkg::ONE_Q30 - smag;
      ejck_pkg::OP_QSIN: begin
        unique case (req_q.k)
          2'd0: res_o = a_q;
          2'd1: res_o = b_q;
          2'd2: res_o = -a_q;
          default: res_o = -b_q;
        endcase
      end
      ejck_pkg::OP_QCOS: begin
        unique case (req_q.k)
          2'd0: res_o = b_q;
          2'd1: res_o = -a_q;
          2'd2: res_o = -b_q;
          default: res_o = a_q;
        endcase
      end
      default: res_o = a_q;
    endcase
  end

  assign done_o = v_q[3];

endmodule
`default_nettype wire

[rtl/euler_joint_chain_kinematics.sv]
// Forward kinematics of a segment chain, one segment per input word.
// Input stream: s_axis_tvalid/tready/tdata carry the segment, its parent and
// three joint angles (Q3.13 radians). Output stream: m_axis_tvalid/tready/tdata
// carry the segment and its nine global rotation elements (Q2.14, saturated),
// which are also kept in an internal matrix table for later children.
// The root (segment 0) takes Rx*Ry*Rz, any other segment parent*Ry*Rx*Rz; a
// parent at or beyond SEGMENTS is taken as the identity. Parents must be sent
// before their children.
// A single shared multiply and divide unit runs 99 micro-operations (sine and
// cosine series for three angles, then three matrix rotations), plus angle
// reduction, parent load and result write-back.
// The block accepts one word at a time; s_axis_tready is high only while idle,
// so the next word is taken only once the last one's write-back is done.
// A finished result waits in the output register; the next word is accepted
// meanwhile and only its write-back waits for the receiver to take that result.
// Reset clears control state; the matrix table holds nothing defined until a
// segment has been written.
`default_nettype none
module euler_joint_chain_kinematics #(
  parameter int SEGMENTS = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // segment_index, parent_index, angle_x, angle_y, angle_z
  input  wire logic [63:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_segment, m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [151:0]      m_axis_tdata
);

  localparam int TBL_D = SEGMENTS * 9;
  localparam int TBL_AW = $clog2(TBL_D);

  ejck_pkg::state_e state_q, state_d;

  logic [4:0]         seg_q;
  logic [4:0]         par_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic [3:0]         cnt_q;
  logic [1:0]         ang_q;
  logic [4:0]         pc_q;
  logic               rot_q;
  logic [1:0]         rn_q;
  logic [1:0]         row_q;
  logic [2:0]         step_q;
  logic signed [33:0] r_q;
  logic [1:0]         k_q;
  logic [2:0]         guard_q;
  logic               phase_q;
  logic               out_valid_q;
  logic [4:0]         out_seg_q;
  logic [15:0]        out_m_q [9];

  ejck_pkg::val_t rf [ejck_pkg::RF_DEPTH];
  ejck_pkg::val_t rf_rd0_q, rf_rd1_q;
  ejck_pkg::ra_t  rf_ra0, rf_ra1, rf_wa;
  ejck_pkg::val_t rf_wd;
  logic           rf_we;

  logic [15:0]       tbl [TBL_D];
  logic [15:0]       tbl_rd_q;
  logic [TBL_AW-1:0] tbl_ra, tbl_wa;
  logic              tbl_we;

  ejck_pkg::uop_t     uop;
  ejck_pkg::axis_e    axis;
  ejck_pkg::alu_req_t alu_req;
  ejck_pkg::val_t     alu_res;
  logic               alu_done;
  logic               alu_start;

  logic        in_acc;
  logic        seg_ok, par_ok, ident;
  logic        red_done;
  logic        sub_go, add_go;
  logic        trig_end, rot_end;
  logic [8:0]  seg_base, par_base;
  logic [3:0]  cm1;
  logic [39:0] o_abs;
  logic [39:0] o_rnd;
  logic [23:0] o_mag;
  logic [15:0] o_q14;
  logic signed [15:0] ang_next;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ejck_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign seg_ok = 32'(seg_q) < SEGMENTS;
  assign par_ok = 32'(par_q) < SEGMENTS;
  assign seg_base = ({4'b0, seg_q} << 3) + {4'b0, seg_q};
  assign par_base = ({4'b0, par_q} << 3) + {4'b0, par_q};
  assign cm1 = cnt_q - 4'd1;

  assign sub_go = (guard_q < 3'd4) && (r_q > ejck_pkg::QUARTER_PI_Q30);
  assign add_go = (guard_q < 3'd4) && (r_q < -ejck_pkg::QUARTER_PI_Q30);
  assign red_done = phase_q && !add_go;

  always_comb begin
    if (seg_q == 5'd0) begin
      axis = ejck_pkg::axis_e'(rn_q);
    end else begin
      unique case (rn_q)
        2'd0: axis = ejck_pkg::AX_Y;
        2'd1: axis = ejck_pkg::AX_X;
        default: axis = ejck_pkg::AX_Z;
      endcase
    end
    uop = rot_q ? ejck_pkg::rot_uop(step_q, row_q, axis) : ejck_pkg::trig_uop(pc_q, ang_q);
    alu_req.op = uop.op;
    alu_req.dix = uop.dix;
    alu_req.acc = uop.acc;
    alu_req.neg = uop.neg;
    alu_req.k = k_q;
  end

  assign trig_end = !rot_q && (pc_q == ejck_pkg::TRIG_LAST);
  assign rot_end = rot_q && (rn_q == 2'd2) && (row_q == 2'd2) && (step_q == 3'd4);
  assign alu_start = (state_q == ejck_pkg::ST_OPST);
  assign ang_next = (ang_q == 2'd0) ? ay_q : az_q;

  ejck_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .req_i   (alu_req),
    .a_i     (rf_rd0_q),
    .b_i     (rf_rd1_q),
    .c_i     (rf_rd0_q),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  always_comb begin
    ident = (seg_q == 5'd0) || !par_ok;
    rf_ra1 = uop.b;
    if (state_q == ejck_pkg::ST_OPRD) begin
      rf_ra0 = uop.a;
    end else if (state_q == ejck_pkg::ST_OUT) begin
      rf_ra0 = ejck_pkg::RA_M0 + 5'(cnt_q);
    end else begin
      rf_ra0 = uop.c;
    end
    rf_we = 1'b0;
    rf_wa = uop.dst;
    rf_wd = alu_res;
    if (state_q == ejck_pkg::ST_LOAD && cnt_q != 4'd0) begin
      rf_we = 1'b1;
      rf_wa = 5'(cm1);
      if (ident) begin
        rf_wd = (cm1 == 4'd0 || cm1 == 4'd4 || cm1 == 4'd8) ? ejck_pkg::ONE_Q30 : '0;
      end else begin
        rf_wd = 40'($signed(tbl_rd_q)) <<< 16;
      end
    end else if (state_q == ejck_pkg::ST_RED && red_done) begin
      rf_we = 1'b1;
      rf_wa = ejck_pkg::RA_R;
      rf_wd = 40'(r_q);
    end else if (state_q == ejck_pkg::ST_OPWT && alu_done) begin
      rf_we = 1'b1;
    end
    tbl_ra = TBL_AW'(par_base + 9'(cnt_q));
    tbl_wa = TBL_AW'(seg_base + 9'(cm1));
    tbl_we = (state_q == ejck_pkg::ST_OUT) && (cnt_q != 4'd0) && seg_ok;
  end

  always_comb begin
    o_abs = rf_rd0_q[39] ? 40'(-rf_rd0_q) : 40'(rf_rd0_q);
    o_rnd = o_abs + 40'd32768;
    o_mag = o_rnd[39:16];
    if (!rf_rd0_q[39]) begin
      o_q14 = (o_mag > 24'd32767) ? 16'h7fff : o_mag[15:0];
    end else begin
      o_q14 = (o_mag > 24'd32768) ? 16'h8000 : 16'(-o_mag[15:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    rf_rd0_q <= rf[rf_ra0];
    rf_rd1_q <= rf[rf_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl[tbl_wa] <= o_q14;
    end
    tbl_rd_q <= tbl[tbl_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ejck_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ejck_pkg::ST_IDLE: if (in_acc) state_d = ejck_pkg::ST_LOAD;
      ejck_pkg::ST_LOAD: if (cnt_q == 4'd9) state_d = ejck_pkg::ST_RED;
      ejck_pkg::ST_RED:  if (red_done) state_d = ejck_pkg::ST_OPRD;
      ejck_pkg::ST_OPRD: state_d = ejck_pkg::ST_OPST;
      ejck_pkg::ST_OPST: state_d = ejck_pkg::ST_OPWT;
      ejck_pkg::ST_OPWT: begin
        if (alu_done) begin
          priority if (rot_end) begin
            state_d = ejck_pkg::ST_WAIT;
          end else if (trig_end && ang_q != 2'd2) begin
            state_d = ejck_pkg::ST_RED;
          end else begin
            state_d = ejck_pkg::ST_OPRD;
          end
        end
      end
      ejck_pkg::ST_WAIT: if (!out_valid_q) state_d = ejck_pkg::ST_OUT;
      ejck_pkg::ST_OUT:  if (cnt_q == 4'd9) state_d = ejck_pkg::ST_IDLE;
      default: state_d = ejck_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ang_q <= '0;
      pc_q <= '0;
      rot_q <= 1'b0;
      rn_q <= '0;
      row_q <= '0;
      step_q <= '0;
      k_q <= '0;
      guard_q <= '0;
      phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ejck_pkg::ST_IDLE: begin
          cnt_q <= '0;
          ang_q <= '0;
          pc_q <= '0;
          rot_q <= 1'b0;
        end
        ejck_pkg::ST_LOAD: begin
          cnt_q <= cnt_q + 4'd1;
          k_q <= '0;
          guard_q <= '0;
          phase_q <= 1'b0;
        end
        ejck_pkg::ST_RED: begin
          if (!phase_q) begin
            if (sub_go) begin
              k_q <= k_q + 2'd1;
              guard_q <= guard_q + 3'd1;
            end else begin
              phase_q <= 1'b1;
              guard_q <= '0;
            end
          end else if (add_go) begin
            k_q <= k_q + 2'd3;
            guard_q <= guard_q + 3'd1;
          end
        end
        ejck_pkg::ST_OPWT: begin
          if (alu_done) begin
            if (!rot_q) begin
              if (trig_end) begin
                pc_q <= '0;
                if (ang_q == 2'd2) begin
                  rot_q <= 1'b1;
                  rn_q <= '0;
                  row_q <= '0;
                  step_q <= '0;
                end else begin
                  ang_q <= ang_q + 2'd1;
                  k_q <= '0;
                  guard_q <= '0;
                  phase_q <= 1'b0;
                end
              end else begin
                pc_q <= pc_q + 5'd1;
              end
            end else if (step_q == 3'd4) begin
              step_q <= '0;
              if (row_q == 2'd2) begin
                row_q <= '0;
                rn_q <= rn_q + 2'd1;
              end else begin
                row_q <= row_q + 2'd1;
              end
            end else begin
              step_q <= step_q + 3'd1;
            end
          end
        end
        ejck_pkg::ST_WAIT: cnt_q <= '0;
        ejck_pkg::ST_OUT: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd9) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seg_q <= s_axis_tdata[4:0];
      par_q <= s_axis_tdata[9:5];
      ax_q <= s_axis_tdata[25:10];
      ay_q <= s_axis_tdata[41:26];
      az_q <= s_axis_tdata[57:42];
    end
    if (state_q == ejck_pkg::ST_LOAD) begin
      r_q <= {ax_q[15], ax_q, 17'b0};
    end else if (state_q == ejck_pkg::ST_RED) begin
      if (!phase_q && sub_go) begin
        r_q <= r_q - ejck_pkg::HALF_PI_Q30;
      end else if (phase_q && add_go) begin
        r_q <= r_q + ejck_pkg::HALF_PI_Q30;
      end
    end else if (state_q == ejck_pkg::ST_OPWT && alu_done && trig_end) begin
      r_q <= {ang_next[15], ang_next, 17'b0};
    end
    if (state_q == ejck_pkg::ST_OUT && cnt_q != 4'd0) begin
      out_m_q[cm1] <= o_q14;
    end
    if (state_q == ejck_pkg::ST_OUT && cnt_q == 4'd9) begin
      out_seg_q <= seg_q;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[4:0] = out_seg_q;
    for (int n = 0; n < 9; n++) begin
      m_axis_tdata[5 + 16 * n +: 16] = out_m_q[n];
    end
  end

  a_alu_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q == ejck_pkg::ST_OPWT)
    else $error("shared unit finished outside an operation");

  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> seg_ok)
    else $error("matrix table written for a segment out of range");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ejck_pkg::ST_LOAD)
    else $error("accepted word did not start a parent load");

  a_reduced_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ejck_pkg::ST_RED && red_done) |->
      (r_q <= ejck_pkg::QUARTER_PI_Q30 && r_q >= -ejck_pkg::QUARTER_PI_Q30))
    else $error("reduced angle outside a quarter turn");

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;

  localparam int  NSEG     = 32;
  localparam int  DRAIN    = 800;
  localparam longint LIMIT = 8000000;
  localparam longint Q30   = 64'sd1073741824;
  localparam longint HPI   = 64'sd1686629713;
  localparam longint QPI   = 64'sd843314856;

  typedef longint mat_t[9];
  typedef struct {
    logic [4:0]         seg;
    logic signed [15:0] m[9];
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;

  euler_joint_chain_kinematics u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  logic signed [15:0] pose_table[NSEG*9];
  bit written[NSEG];
  pose_t pending_poses[$];
  int errors = 0;
  int words_sent = 0;
  int poses_seen = 0;
  int send_idle = 0;
  int recv_stall = 0;
  longint cycles = 0;
  int parent_of[23] = '{0, 0, 1, 2, 3, 4, 5, 4, 7, 8, 9, 4, 11, 12, 13,
                        0, 15, 16, 17, 0, 19, 20, 21};

  function automatic longint round_div(longint p, longint d);
    if (p >= 0) return (p + d / 2) / d;
    return -((-p + d / 2) / d);
  endfunction

  function automatic longint fmul(longint a, longint b);
    return round_div(a * b, Q30);
  endfunction

  function automatic void sin_cos(input logic signed [15:0] ang, output longint s_o,
                                  output longint c_o);
    longint r, x2, t, s, c;
    int unsigned k;
    r = longint'(ang) * 131072;
    k = 0;
    for (int g = 0; g < 4 && r > QPI; g++) begin
      r -= HPI;
      k += 1;
    end
    for (int g = 0; g < 4 && r < -QPI; g++) begin
      r += HPI;
      k += 3;
    end
    x2 = fmul(r, r);
    t = Q30 - round_div(x2, 72);
    t = Q30 - round_div(fmul(x2, t), 42);
    t = Q30 - round_div(fmul(x2, t), 20);
    t = Q30 - round_div(fmul(x2, t), 6);
    s = fmul(r, t);
    t = Q30 - round_div(x2, 56);
    t = Q30 - round_div(fmul(x2, t), 30);
    t = Q30 - round_div(fmul(x2, t), 12);
    c = Q30 - round_div(fmul(x2, t), 2);
    case (k & 3)
      0: begin s_o = s;  c_o = c;  end
      1: begin s_o = c;  c_o = -s; end
      2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endfunction

  function automatic void mat_mul(input mat_t a, input mat_t b, output mat_t o);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        o[i*3+j] = fmul(a[i*3], b[j]) + fmul(a[i*3+1], b[3+j])
                 + fmul(a[i*3+2], b[6+j]);
  endfunction

  function automatic pose_t predict_pose(logic [4:0] seg, logic [4:0] par,
                                         logic signed [15:0] ax,
                                         logic signed [15:0] ay,
                                         logic signed [15:0] az);
    longint sx, cx, sy, cy, sz, cz, v;
    mat_t rx, ry, rz, p, t1, t2, res;
    pose_t pr;
    sin_cos(ax, sx, cx);
    sin_cos(ay, sy, cy);
    sin_cos(az, sz, cz);
    rx = '{Q30, 0, 0, 0, cx, -sx, 0, sx, cx};
    ry = '{cy, 0, sy, 0, Q30, 0, -sy, 0, cy};
    rz = '{cz, -sz, 0, sz, cz, 0, 0, 0, Q30};
    if (seg == 0) begin
      mat_mul(rx, ry, t1);
      mat_mul(t1, rz, res);
    end else begin
      for (int i = 0; i < 9; i++)
        p[i] = longint'(pose_table[par*9+i]) * 65536;
      mat_mul(p, ry, t1);
      mat_mul(t1, rx, t2);
      mat_mul(t2, rz, res);
    end
    pr.seg = seg;
    for (int i = 0; i < 9; i++) begin
      v = round_div(res[i], 65536);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      pr.m[i] = v[15:0];
      pose_table[seg*9+i] = v[15:0];
    end
    written[seg] = 1'b1;
    return pr;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 30)
      $display("MISMATCH %s: got %0d, expected %0d (pose %0d)", what, got, want,
               poses_seen);
  endtask

  task automatic send_word(logic [4:0] seg, logic [4:0] par, logic signed [15:0] ax,
                           logic signed [15:0] ay, logic signed [15:0] az);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'd0, az, ay, ax, par, seg};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
      @(negedge clk_i);
    end
    pending_poses.push_back(predict_pose(seg, par, ax, ay, az));
    words_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic signed [15:0] joint_angle();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
  endfunction

  function automatic logic [4:0] known_parent();
    logic [4:0] p;
    do p = 5'($urandom_range(0, NSEG - 1)); while (!written[p]);
    return p;
  endfunction

  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);

  always @(posedge clk_i) begin
    pose_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      poses_seen++;
      if (pending_poses.size() == 0) begin
        report_mismatch("unexpected pose, segment", m_axis_tdata[4:0], -1);
      end else begin
        want = pending_poses.pop_front();
        if (m_axis_tdata[4:0] !== want.seg)
          report_mismatch("segment", m_axis_tdata[4:0], want.seg);
        for (int i = 0; i < 9; i++)
          if (m_axis_tdata[5+16*i +: 16] !== want.m[i])
            report_mismatch($sformatf("m%0d%0d", i / 3, i % 3),
                            $signed(m_axis_tdata[5+16*i +: 16]), want.m[i]);
      end
    end
  end

  task automatic test_extremes();
    logic signed [15:0] ext[5] = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd12868,
                                   -16'sd6434};
    send_word(5'd0, 5'd31, 16'sd0, 16'sd0, 16'sd0);
    send_word(5'd31, 5'd0, 16'sd0, 16'sd0, 16'sd0);
    for (int i = 0; i < 5; i++)
      send_word(5'd0, 5'd0, ext[i], ext[(i+1)%5], ext[(i+2)%5]);
    for (int i = 0; i < 5; i++)
      send_word(5'(i + 1), 5'(i), ext[(i+3)%5], ext[i], ext[(i+4)%5]);
    send_word(5'd31, 5'd31, -16'sd32768, -16'sd32768, -16'sd32768);
    send_word(5'd30, 5'd31, 16'sd32767, 16'sd32767, 16'sd32767);
    send_word(5'd0, 5'd30, 16'sd6434, -16'sd6434, 16'sd6433);
    send_word(5'd5, 5'd5, 16'sd25736, -16'sd25736, 16'sd19302);
  endtask

  task automatic test_skeleton_frames(int frames);
    for (int f = 0; f < frames; f++) begin
      for (int s = 0; s < 23; s++)
        send_word(5'(s), (s == 0) ? 5'($urandom) : 5'(parent_of[s]),
                  joint_angle(), joint_angle(), joint_angle());
      if ($urandom_range(0, 3) == 0)
        send_word(5'($urandom_range(23, 31)), known_parent(),
                  joint_angle(), joint_angle(), joint_angle());
    end
  endtask

  task automatic test_scattered_segments(int n);
    logic [4:0] seg;
    for (int i = 0; i < n; i++) begin
      seg = 5'($urandom);
      send_word(seg, (seg == 0) ? 5'($urandom) : known_parent(),
                16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int s_idle[4] = '{0, 54, 0, 32};
    int r_stall[4] = '{0, 0, 54, 32};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = s_idle[ph];
      recv_stall = r_stall[ph];
      test_skeleton_frames(14);
      test_scattered_segments(30);
    end
    send_idle = 0;
    recv_stall = 0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("Sent %0d words and checked %0d poses over four idling phases,", words_sent,
             poses_seen);
    $display("covering full skeleton frames, scattered segments and angle extremes.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
